// File: hw/rtl/integral_record_owner_scatter_assert.svh
// assertion macros for the integral record owner scatter block
`ifndef INTEGRAL_RECORD_OWNER_SCATTER_ASSERT_SVH
`define INTEGRAL_RECORD_OWNER_SCATTER_ASSERT_SVH
`ifndef SYNTHESIS
`define IRS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("irs: same-cycle check failed");
`define IRS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("irs: next-cycle check failed");
`else
`define IRS_ASSERT_NOW(label, ante, cons)
`define IRS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/irs_pkg.sv
`default_nettype none
package irs_pkg;

   localparam int MAX_ORBITALS    = 255;
   localparam int MAX_PROCESSES   = 1024;
   localparam int INDEX_WIDTH     = 8;
   localparam int DATA_WIDTH      = 64;
   localparam int PROC_WIDTH      = 11;
   localparam int RANK_WIDTH      = 10;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 11;

   // owner arithmetic: triangle index fits 15 bits, reduced 3 bits a step
   localparam int TRI_WIDTH     = 15;
   localparam int DIV_STEP_BITS = 3;
   localparam int DIV_STEPS     = TRI_WIDTH / DIV_STEP_BITS;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ORBITAL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_COUNT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MY_RANK       = 2'd2;

   typedef enum logic [1:0] {
      TGT_CORE = 2'd0,
      TGT_ONE  = 2'd1,
      TGT_TWO  = 2'd2
   } irs_target_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] orbital_count;
      logic [PROC_WIDTH-1:0]  process_count;
      logic [RANK_WIDTH-1:0]  my_rank;
   } irs_cfg_type;

   // one owned record waiting for the write sequencer
   typedef struct packed {
      irs_target_type         target;
      logic [INDEX_WIDTH-1:0] a;
      logic [INDEX_WIDTH-1:0] b;
      logic [INDEX_WIDTH-1:0] c;
      logic [INDEX_WIDTH-1:0] d;
      logic [DATA_WIDTH-1:0]  data;
   } irs_entry_type;

endpackage
`default_nettype wire

// File: hw/rtl/irs_front.sv
`default_nettype none
module irs_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire irs_pkg::irs_cfg_type                cfg,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [irs_pkg::DATA_WIDTH-1:0]      req_coefficient_bits,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_i,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_j,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_k,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_l,
   input  wire logic                                queue_full,
   output logic                                     push,
   output irs_pkg::irs_entry_type                   push_entry
);
   import irs_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_DIV  = 3'b010,
      S_PUSH = 3'b100
   } front_state_type;

   localparam logic [PROC_WIDTH-1:0] MAX_P = PROC_WIDTH'(MAX_PROCESSES);
   localparam int CNT_WIDTH = $clog2(DIV_STEPS);

   // input holding register
   logic                   rec_valid_ff, rec_valid_in;
   logic [DATA_WIDTH-1:0]  rec_data_ff, rec_data_in;
   logic [INDEX_WIDTH-1:0] rec_i_ff, rec_j_ff, rec_k_ff, rec_l_ff;
   logic [INDEX_WIDTH-1:0] rec_i_in, rec_j_in, rec_k_in, rec_l_in;

   front_state_type state_ff, state_in;
   irs_entry_type   ent_ff, ent_in;
   logic [TRI_WIDTH-1:0]  quot_ff, quot_in;
   logic [RANK_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0]  cnt_ff, cnt_in;

   logic accept, rec_take;
   logic [PROC_WIDTH-1:0]  eff_p;
   logic [INDEX_WIDTH-1:0] norbs, split_n;
   logic [INDEX_WIDTH-1:0] ia, ib, ic, id;
   logic [INDEX_WIDTH-1:0] s0a, s1a, s2a, s3a, s0b, s1b, s2b, s3b, w, x, y, z;
   logic [INDEX_WIDTH-1:0] hi, lo, tri_h, tri_l;
   logic [2*INDEX_WIDTH-1:0] tri_prod;
   logic [TRI_WIDTH-1:0]   tri_v, one_div, two_div;
   logic is_core, core_ok, ij_ok, is_one, is_two;
   logic [RANK_WIDTH-1:0]  rem_next;

   assign busy     = rec_valid_ff && !rec_take;
   assign accept   = start && !busy;
   assign rec_take = rec_valid_ff && (state_ff == S_IDLE);

   always_comb begin
      if (cfg.process_count == '0) begin
         eff_p = PROC_WIDTH'(1);
      end else if (cfg.process_count > MAX_P) begin
         eff_p = MAX_P;
      end else begin
         eff_p = cfg.process_count;
      end
   end

   assign norbs   = cfg.orbital_count;
   assign split_n = {1'b0, norbs[INDEX_WIDTH-1:1]} + INDEX_WIDTH'(1);

   assign ia = rec_i_ff - INDEX_WIDTH'(1);
   assign ib = rec_j_ff - INDEX_WIDTH'(1);
   assign ic = rec_k_ff - INDEX_WIDTH'(1);
   assign id = rec_l_ff - INDEX_WIDTH'(1);

   // zero patterns and range checks
   assign is_core = (rec_i_ff == '0) && (rec_j_ff == '0);
   assign core_ok = is_core && (rec_k_ff == '0) && (rec_l_ff == '0) && (cfg.my_rank == '0);
   assign ij_ok   = (rec_i_ff != '0) && (rec_j_ff != '0)
                    && (rec_i_ff <= norbs) && (rec_j_ff <= norbs);
   assign is_one  = ij_ok && (rec_k_ff == '0) && (rec_l_ff == '0);
   assign is_two  = ij_ok && (rec_k_ff != '0) && (rec_l_ff != '0)
                    && (rec_k_ff <= norbs) && (rec_l_ff <= norbs);

   // five compare-exchange sorting network
   always_comb begin
      s0a = (ia < ib) ? ia : ib;
      s1a = (ia < ib) ? ib : ia;
      s2a = (ic < id) ? ic : id;
      s3a = (ic < id) ? id : ic;
      s0b = (s0a < s2a) ? s0a : s2a;
      s2b = (s0a < s2a) ? s2a : s0a;
      s1b = (s1a < s3a) ? s1a : s3a;
      s3b = (s1a < s3a) ? s3a : s1a;
      w   = s0b;
      z   = s3b;
      x   = (s1b < s2b) ? s1b : s2b;
      y   = (s1b < s2b) ? s2b : s1b;
   end

   assign hi = (ia > ib) ? ia : ib;
   assign lo = (ia > ib) ? ib : ia;

   // shared triangle index
   assign tri_h    = is_two ? x : hi;
   assign tri_l    = is_two ? w : lo;
   assign tri_prod = (2*INDEX_WIDTH)'(tri_h) * ((2*INDEX_WIDTH)'(tri_h) + (2*INDEX_WIDTH)'(1));
   assign tri_v    = TRI_WIDTH'(tri_prod[2*INDEX_WIDTH-1:1]) + TRI_WIDTH'(tri_l);

   assign one_div = ((hi >= split_n) && (lo < split_n)) ? TRI_WIDTH'(lo) : tri_v;
   assign two_div = (x >= split_n) ? TRI_WIDTH'(w)
                  : (y >= split_n) ? tri_v : TRI_WIDTH'(z);

   // restoring remainder, a few bits a step
   always_comb begin
      logic [RANK_WIDTH-1:0] r;
      logic [TRI_WIDTH-1:0]  qs;
      logic [PROC_WIDTH-1:0] t;
      r  = rem_ff;
      qs = quot_ff;
      t  = '0;
      for (int s = 0; s < DIV_STEP_BITS; s++) begin
         t = {r, qs[TRI_WIDTH-1]};
         if (t >= eff_p) begin
            t = t - eff_p;
         end
         r  = t[RANK_WIDTH-1:0];
         qs = qs << 1;
      end
      rem_next = r;
   end

   always_comb begin
      rec_valid_in = rec_valid_ff;
      rec_data_in  = rec_data_ff;
      rec_i_in     = rec_i_ff;
      rec_j_in     = rec_j_ff;
      rec_k_in     = rec_k_ff;
      rec_l_in     = rec_l_ff;
      if (accept) begin
         rec_valid_in = 1'b1;
         rec_data_in  = req_coefficient_bits;
         rec_i_in     = req_index_i;
         rec_j_in     = req_index_j;
         rec_k_in     = req_index_k;
         rec_l_in     = req_index_l;
      end else if (rec_take) begin
         rec_valid_in = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (rec_valid_ff) begin
               ent_in.data = rec_data_ff;
               quot_in     = is_two ? two_div : one_div;
               rem_in      = '0;
               cnt_in      = '0;
               if (is_one) begin
                  ent_in.target = TGT_ONE;
                  ent_in.a      = ia;
                  ent_in.b      = ib;
                  ent_in.c      = '0;
                  ent_in.d      = '0;
                  state_in      = S_DIV;
               end else if (is_two) begin
                  ent_in.target = TGT_TWO;
                  ent_in.a      = ia;
                  ent_in.b      = ib;
                  ent_in.c      = ic;
                  ent_in.d      = id;
                  state_in      = S_DIV;
               end else if (core_ok) begin
                  ent_in.target = TGT_CORE;
                  ent_in.a      = '0;
                  ent_in.b      = '0;
                  ent_in.c      = '0;
                  ent_in.d      = '0;
                  state_in      = S_PUSH;
               end
            end
         end
         S_DIV: begin
            rem_in  = rem_next;
            quot_in = quot_ff << DIV_STEP_BITS;
            cnt_in  = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1)) begin
               if (rem_next != cfg.my_rank) begin
                  state_in = S_IDLE;
               end else if (!queue_full) begin
                  push     = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_PUSH;
               end
            end
         end
         S_PUSH: begin
            if (!queue_full) begin
               push     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign push_entry = ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_valid_ff <= 1'b0;
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
      end else begin
         rec_valid_ff <= rec_valid_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_data_ff <= rec_data_in;
      rec_i_ff    <= rec_i_in;
      rec_j_ff    <= rec_j_in;
      rec_k_ff    <= rec_k_in;
      rec_l_ff    <= rec_l_in;
      ent_ff      <= ent_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
   end

endmodule
`default_nettype wire

// File: hw/rtl/irs_queue.sv
`default_nettype none
module irs_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire irs_pkg::irs_entry_type  push_entry,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         head_valid,
   output irs_pkg::irs_entry_type       head_entry
);
   import irs_pkg::*;

   // two entries: one being written out, one waiting
   irs_entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/irs_back.sv
`default_nettype none
module irs_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            head_valid,
   input  wire irs_pkg::irs_entry_type          head_entry,
   output logic                                 pop,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_target_array,
   output logic [irs_pkg::INDEX_WIDTH-1:0]      rsp_addr_a,
   output logic [irs_pkg::INDEX_WIDTH-1:0]      rsp_addr_b,
   output logic [irs_pkg::INDEX_WIDTH-1:0]      rsp_addr_c,
   output logic [irs_pkg::INDEX_WIDTH-1:0]      rsp_addr_d,
   output logic [irs_pkg::DATA_WIDTH-1:0]       rsp_write_data,
   output logic                                 rsp_last_write
);
   import irs_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       strobe_ff;
   logic [1:0] target_ff;
   logic [INDEX_WIDTH-1:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [DATA_WIDTH-1:0]  data_ff;
   logic       last_ff, last_in;
   logic [INDEX_WIDTH-1:0] ea, eb, ec, ed;

   assign ea = head_entry.a;
   assign eb = head_entry.b;
   assign ec = head_entry.c;
   assign ed = head_entry.d;

   // address permutation for the current step
   always_comb begin
      a_in    = '0;
      b_in    = '0;
      c_in    = '0;
      d_in    = '0;
      last_in = 1'b1;
      case (head_entry.target)
         TGT_CORE: begin
            last_in = 1'b1;
         end
         TGT_ONE: begin
            a_in    = step_ff[0] ? eb : ea;
            b_in    = step_ff[0] ? ea : eb;
            last_in = step_ff[0];
         end
         TGT_TWO: begin
            last_in = (step_ff == 3'd7);
            case (step_ff)
               3'd0: begin a_in = ea; b_in = ec; c_in = eb; d_in = ed; end
               3'd1: begin a_in = ea; b_in = ed; c_in = eb; d_in = ec; end
               3'd2: begin a_in = eb; b_in = ec; c_in = ea; d_in = ed; end
               3'd3: begin a_in = eb; b_in = ed; c_in = ea; d_in = ec; end
               3'd4: begin a_in = ec; b_in = ea; c_in = ed; d_in = eb; end
               3'd5: begin a_in = ec; b_in = eb; c_in = ed; d_in = ea; end
               3'd6: begin a_in = ed; b_in = ea; c_in = ec; d_in = eb; end
               default: begin a_in = ed; b_in = eb; c_in = ec; d_in = ea; end
            endcase
         end
         default: begin
            last_in = 1'b1;
         end
      endcase
   end

   assign pop     = head_valid && last_in;
   assign step_in = !head_valid ? step_ff : (last_in ? 3'd0 : step_ff + 3'd1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= 3'd0;
         strobe_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         strobe_ff <= head_valid;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= head_entry.target;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      d_ff      <= d_in;
      data_ff   <= head_entry.data;
      last_ff   <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_target_array = target_ff;
   assign rsp_addr_a       = a_ff;
   assign rsp_addr_b       = b_ff;
   assign rsp_addr_c       = c_ff;
   assign rsp_addr_d       = d_ff;
   assign rsp_write_data   = data_ff;
   assign rsp_last_write   = last_ff;

endmodule
`default_nettype wire

// File: hw/rtl/integral_record_owner_scatter.sv
// a core record goes through the holding, entry, queue and rsp registers before its write
// others run 5 remainder steps first; the front can take the next record while dividing
// the sequencer puts out one write a cycle while a record is queued, 8 for a two-electron one
// the receiver cannot stall: each write is on the rsp ports for exactly one cycle
// synchronous reset clears control and sets orbital_count 1, process_count 1, my_rank 0
`default_nettype none
`include "integral_record_owner_scatter_assert.svh"
module integral_record_owner_scatter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [irs_pkg::DATA_WIDTH-1:0]      req_coefficient_bits,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_i,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_j,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_k,
   input  wire logic [irs_pkg::INDEX_WIDTH-1:0]     req_index_l,
   output logic                                     rsp_strobe,
   output logic [1:0]                               rsp_target_array,
   output logic [irs_pkg::INDEX_WIDTH-1:0]          rsp_addr_a,
   output logic [irs_pkg::INDEX_WIDTH-1:0]          rsp_addr_b,
   output logic [irs_pkg::INDEX_WIDTH-1:0]          rsp_addr_c,
   output logic [irs_pkg::INDEX_WIDTH-1:0]          rsp_addr_d,
   output logic [irs_pkg::DATA_WIDTH-1:0]           rsp_write_data,
   output logic                                     rsp_last_write,
   input  wire logic                                csr_write_enable,
   input  wire logic [irs_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [irs_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import irs_pkg::*;

   // configuration registers; the user writes them only while the block is idle, unchecked
   logic [INDEX_WIDTH-1:0] orbital_count_ff, orbital_count_in;
   logic [PROC_WIDTH-1:0]  process_count_ff, process_count_in;
   logic [RANK_WIDTH-1:0]  my_rank_ff, my_rank_in;
   irs_cfg_type            cfg;

   // front to queue, queue to back
   logic          push, queue_full, pop, head_valid;
   irs_entry_type push_entry, head_entry;

   always_comb begin
      orbital_count_in = orbital_count_ff;
      process_count_in = process_count_ff;
      my_rank_in       = my_rank_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ORBITAL_COUNT: orbital_count_in = csr_write_data[INDEX_WIDTH-1:0];
            CSR_PROCESS_COUNT: process_count_in = csr_write_data[PROC_WIDTH-1:0];
            CSR_MY_RANK:       my_rank_in       = csr_write_data[RANK_WIDTH-1:0];
            default: begin
               // unmapped index, write ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         orbital_count_ff <= INDEX_WIDTH'(1);
         process_count_ff <= PROC_WIDTH'(1);
         my_rank_ff       <= '0;
      end else begin
         orbital_count_ff <= orbital_count_in;
         process_count_ff <= process_count_in;
         my_rank_ff       <= my_rank_in;
      end
   end

   assign cfg.orbital_count = orbital_count_ff;
   assign cfg.process_count = process_count_ff;
   assign cfg.my_rank       = my_rank_ff;

   // front: holds one transaction, classifies it, works out the owner rank
   irs_front u_front (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg),
      .start                (start),
      .busy                 (busy),
      .req_coefficient_bits (req_coefficient_bits),
      .req_index_i          (req_index_i),
      .req_index_j          (req_index_j),
      .req_index_k          (req_index_k),
      .req_index_l          (req_index_l),
      .queue_full           (queue_full),
      .push                 (push),
      .push_entry           (push_entry)
   );

   // two-deep queue of owned records
   irs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // back: steps through the symmetric writes of the head record
   irs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_target_array (rsp_target_array),
      .rsp_addr_a       (rsp_addr_a),
      .rsp_addr_b       (rsp_addr_b),
      .rsp_addr_c       (rsp_addr_c),
      .rsp_addr_d       (rsp_addr_d),
      .rsp_write_data   (rsp_write_data),
      .rsp_last_write   (rsp_last_write)
   );

   // core energy is a single write
   `IRS_ASSERT_NOW(a_core_single, rsp_strobe && (rsp_target_array == TGT_CORE), rsp_last_write)
   // the writes of one record follow each other without a gap
   `IRS_ASSERT_NEXT(a_no_gap, rsp_strobe && !rsp_last_write, rsp_strobe)
   // and carry the same coefficient
   `IRS_ASSERT_NEXT(a_same_data, rsp_strobe && !rsp_last_write, $stable(rsp_write_data))

endmodule
`default_nettype wire
